FILE: design/dre_pkg.sv
// Shared types, constants and helpers for the dirty rectangle extractor.
`default_nettype none
package dre_pkg;

  localparam int LINE_PIXELS_DEF = 160;
  localparam int MAX_LINES_DEF   = 256;
  localparam int QUEUE_DEPTH_DEF = 256;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 9;

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE        = 2'd2;

  localparam logic [7:0] FRAME_WIDTH_RST  = 8'd160;
  localparam logic [8:0] FRAME_HEIGHT_RST = 9'd210;
  localparam logic [1:0] SCALE_RST        = 2'd2;

  localparam logic CMD_PIXEL = 1'b0;
  localparam logic CMD_DRAIN = 1'b1;

  typedef struct packed {
    logic       cmd;
    logic [7:0] new_pixel;
    logic [7:0] old_pixel;
    logic       redraw_all;
  } in_item_t;

  typedef struct packed {
    logic       rect_valid;
    logic [9:0] rect_x;
    logic [9:0] rect_y;
    logic [9:0] rect_width;
    logic [9:0] rect_height;
    logic [7:0] rect_color;
    logic       queue_empty;
    logic       overflow;
  } out_item_t;

  // Classified item handed from the front end to the back end.
  typedef struct packed {
    logic       cmd;
    logic       changed;
    logic [7:0] color;
  } front_item_t;

  typedef struct packed {
    logic [7:0] color;
    logic [7:0] x;
    logic [7:0] y;
    logic [8:0] w;
    logic [8:0] h;
  } run_t;

  typedef struct packed {
    logic [8:0] effw;
    logic [8:0] effh;
    logic [1:0] scale;
  } cfg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_WALK_RD,
    ST_WALK_EV,
    ST_REST_RD,
    ST_REST_EV,
    ST_FRAME_RD,
    ST_FRAME_EV,
    ST_POP,
    ST_OUT
  } ctl_state_t;

  function automatic logic [9:0] sat10(input logic [11:0] v);
    logic [9:0] r;
    r = (v > 12'd1023) ? 10'd1023 : v[9:0];
    return r;
  endfunction

endpackage
`default_nettype wire

FILE: design/dre_front.sv
// Input queue that accepts items and classifies pixels as changed or not.
`default_nettype none
module dre_front (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  dre_pkg::in_item_t    in_data,
  output logic                 item_valid,
  output dre_pkg::front_item_t item,
  input  logic                 item_take
);
  import dre_pkg::*;

  front_item_t ent [2];
  logic        wptr;
  logic        rptr;
  logic [1:0]  count;
  logic        push;
  logic        pop;
  front_item_t cls;

  assign in_stall   = (count == 2'd2);
  assign push       = in_valid && !in_stall;
  assign item_valid = (count != 2'd0);
  assign item       = ent[rptr];
  assign pop        = item_take && item_valid;

  always_comb begin
    cls.cmd     = in_data.cmd;
    cls.changed = (in_data.new_pixel != in_data.old_pixel) || in_data.redraw_all;
    cls.color   = in_data.new_pixel;
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ent[wptr] <= cls;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) begin
        wptr <= ~wptr;
      end
      if (pop) begin
        rptr <= ~rptr;
      end
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule
`default_nettype wire

FILE: design/dre_back.sv
// Run building, line-end merge walk, rectangle queue and scaled output register.
`default_nettype none
module dre_back #(
  parameter int LINE_PIXELS = dre_pkg::LINE_PIXELS_DEF,
  parameter int QUEUE_DEPTH = dre_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  dre_pkg::cfg_t        cfg,
  input  logic                 item_valid,
  input  dre_pkg::front_item_t item,
  output logic                 item_take,
  output logic                 out_valid,
  input  logic                 out_stall,
  output dre_pkg::out_item_t   out_data
);
  import dre_pkg::*;

  localparam int IW = (LINE_PIXELS > 1) ? $clog2(LINE_PIXELS) : 1;
  localparam int CW = $clog2(LINE_PIXELS + 1);
  localparam int QW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int FW = $clog2(QUEUE_DEPTH + 1);

  ctl_state_t state, state_next;

  logic [CW-1:0] cc, ac, t, ai, cc_m1;
  logic          bank;
  logic [8:0]    column, row;
  run_t          tail;

  run_t run_mem [2][LINE_PIXELS];
  run_t rd_a, rd_b;
  run_t q_mem [QUEUE_DEPTH];
  run_t q_rd;

  logic [QW-1:0] head, wptr;
  logic [FW-1:0] fill;
  logic          ovf;
  logic          pop_hit;

  logic          run_we;
  logic          run_wbank;
  logic [IW-1:0] run_widx;
  run_t          run_wdata;
  logic          rd_a_en, rd_a_bank, rd_b_en;
  logic          enq;
  run_t          enq_data;
  logic          q_rd_en, out_load;
  logic          pix_ext, pix_new, line_done;
  logic          is_pixel, line_end_hit, row_wrap, walk_go, match, ge;
  logic          q_full;
  run_t          new_run, ext_run, merged;
  logic [11:0]   x_prod, y_prod, w_prod, h_prod;

  assign cc_m1        = cc - CW'(1);
  assign is_pixel     = (item.cmd == CMD_PIXEL);
  assign line_end_hit = ({1'b0, column} + 10'd1) >= {1'b0, cfg.effw};
  assign row_wrap     = ({1'b0, row} + 10'd1) >= {1'b0, cfg.effh};
  assign walk_go      = (t < cc) && (ai < ac);
  assign match        = (rd_a.x == rd_b.x) && (rd_a.w == rd_b.w) &&
                        (rd_a.color == rd_b.color);
  assign ge           = (rd_a.x >= rd_b.x);
  assign q_full       = (fill == FW'(QUEUE_DEPTH));

  always_comb begin
    new_run = '{color: item.color, x: column[7:0], y: row[7:0], w: 9'd1, h: 9'd1};
    ext_run   = tail;
    ext_run.w = tail.w + 9'd1;
    merged    = rd_a;
    merged.y  = rd_b.y;
    merged.h  = rd_b.h + 9'd1;
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (item_valid) begin
          state_next = (is_pixel && line_end_hit) ? ST_WALK_RD : ST_POP;
        end
      end
      ST_WALK_RD:  state_next = walk_go ? ST_WALK_EV : ST_REST_RD;
      ST_WALK_EV:  state_next = ST_WALK_RD;
      ST_REST_RD: begin
        if (ai < ac) begin
          state_next = ST_REST_EV;
        end else begin
          state_next = row_wrap ? ST_FRAME_RD : ST_POP;
        end
      end
      ST_REST_EV:  state_next = ST_REST_RD;
      ST_FRAME_RD: state_next = (t < ac) ? ST_FRAME_EV : ST_POP;
      ST_FRAME_EV: state_next = ST_FRAME_RD;
      ST_POP:      state_next = ST_OUT;
      ST_OUT:      state_next = (!out_valid || !out_stall) ? ST_IDLE : ST_OUT;
      default:     state_next = ST_IDLE;
    endcase
  end

  // Control outputs.
  always_comb begin
    item_take = 1'b0;
    run_we    = 1'b0;
    run_wbank = bank;
    run_widx  = t[IW-1:0];
    run_wdata = merged;
    rd_a_en   = 1'b0;
    rd_a_bank = bank;
    rd_b_en   = 1'b0;
    enq       = 1'b0;
    enq_data  = rd_b;
    q_rd_en   = 1'b0;
    out_load  = 1'b0;
    pix_ext   = 1'b0;
    pix_new   = 1'b0;
    line_done = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (item_valid) begin
          item_take = 1'b1;
          if (is_pixel && item.changed) begin
            if (cc != '0 && tail.color == item.color &&
                ({2'b0, tail.x} + {1'b0, tail.w}) == {1'b0, column}) begin
              pix_ext   = 1'b1;
              run_we    = 1'b1;
              run_widx  = cc_m1[IW-1:0];
              run_wdata = ext_run;
            end else if (cc < CW'(LINE_PIXELS)) begin
              pix_new   = 1'b1;
              run_we    = 1'b1;
              run_widx  = cc[IW-1:0];
              run_wdata = new_run;
            end
          end
        end
      end
      ST_WALK_RD: begin
        if (walk_go) begin
          rd_a_en = 1'b1;
          rd_b_en = 1'b1;
        end
      end
      ST_WALK_EV: begin
        if (match) begin
          run_we = 1'b1;
        end else if (ge) begin
          enq = 1'b1;
        end
      end
      ST_REST_RD: begin
        if (ai < ac) begin
          rd_b_en = 1'b1;
        end else begin
          line_done = 1'b1;
        end
      end
      ST_REST_EV: enq = 1'b1;
      ST_FRAME_RD: begin
        if (t < ac) begin
          rd_a_en   = 1'b1;
          rd_a_bank = ~bank;
        end
      end
      ST_FRAME_EV: begin
        enq      = 1'b1;
        enq_data = rd_a;
      end
      ST_POP: q_rd_en = (fill != '0);
      ST_OUT: out_load = !out_valid || !out_stall;
      default: ;
    endcase
  end

  // Run store: two banks, one write and two registered reads per cycle.
  always_ff @(posedge clk) begin
    if (run_we) begin
      run_mem[run_wbank][run_widx] <= run_wdata;
    end
    if (rd_a_en) begin
      rd_a <= run_mem[rd_a_bank][t[IW-1:0]];
    end
    if (rd_b_en) begin
      rd_b <= run_mem[~bank][ai[IW-1:0]];
    end
  end

  // Rectangle queue storage.
  always_ff @(posedge clk) begin
    if (enq && !q_full) begin
      q_mem[wptr] <= enq_data;
    end
    if (q_rd_en) begin
      q_rd <= q_mem[head];
    end
  end

  always_ff @(posedge clk) begin
    if (pix_ext) begin
      tail <= ext_run;
    end else if (pix_new) begin
      tail <= new_run;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      cc      <= '0;
      ac      <= '0;
      t       <= '0;
      ai      <= '0;
      bank    <= 1'b0;
      column  <= '0;
      row     <= '0;
      head    <= '0;
      wptr    <= '0;
      fill    <= '0;
      ovf     <= 1'b0;
      pop_hit <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_IDLE && item_valid && is_pixel) begin
        column <= column + 9'd1;
        t      <= '0;
        ai     <= '0;
      end
      if (pix_new) begin
        cc <= cc + CW'(1);
      end
      if (state == ST_WALK_EV) begin
        t <= t + CW'(1);
        if (match || ge) begin
          ai <= ai + CW'(1);
        end
      end
      if (state == ST_REST_EV) begin
        ai <= ai + CW'(1);
      end
      if (line_done) begin
        bank   <= ~bank;
        ac     <= cc;
        cc     <= '0;
        column <= '0;
        row    <= row_wrap ? 9'd0 : row + 9'd1;
        t      <= '0;
      end
      if (state == ST_FRAME_RD && !(t < ac)) begin
        ac <= '0;
      end
      if (state == ST_FRAME_EV) begin
        t <= t + CW'(1);
      end
      if (enq) begin
        if (q_full) begin
          ovf <= 1'b1;
        end else begin
          wptr <= (wptr == QW'(QUEUE_DEPTH - 1)) ? '0 : wptr + QW'(1);
          fill <= fill + FW'(1);
        end
      end
      if (state == ST_POP) begin
        pop_hit <= q_rd_en;
        if (q_rd_en) begin
          head <= (head == QW'(QUEUE_DEPTH - 1)) ? '0 : head + QW'(1);
          fill <= fill - FW'(1);
        end
      end
    end
  end

  always_comb begin
    x_prod = 12'({q_rd.x, 1'b0}) * 12'(cfg.scale);
    y_prod = 12'(q_rd.y) * 12'(cfg.scale);
    w_prod = 12'({q_rd.w, 1'b0}) * 12'(cfg.scale);
    h_prod = 12'(q_rd.h) * 12'(cfg.scale);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data.rect_valid  <= pop_hit;
      out_data.rect_x      <= pop_hit ? sat10(x_prod) : 10'd0;
      out_data.rect_y      <= pop_hit ? sat10(y_prod) : 10'd0;
      out_data.rect_width  <= pop_hit ? sat10(w_prod) : 10'd0;
      out_data.rect_height <= pop_hit ? sat10(h_prod) : 10'd0;
      out_data.rect_color  <= pop_hit ? q_rd.color : 8'd0;
      out_data.queue_empty <= (fill == '0);
      out_data.overflow    <= ovf;
    end
  end

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= FW'(QUEUE_DEPTH))
    else $error("queue fill above depth");

  a_enq_states: assert property (@(posedge clk) disable iff (rst)
    enq |-> (state == ST_WALK_EV || state == ST_REST_EV || state == ST_FRAME_EV))
    else $error("enqueue outside a flush step");

  a_pop_count: assert property (@(posedge clk) disable iff (rst)
    (state == ST_POP && fill != '0) |=> fill == $past(fill) - FW'(1))
    else $error("pop did not decrement the fill");

  a_one_take: assert property (@(posedge clk) disable iff (rst)
    item_take |-> state == ST_IDLE)
    else $error("item taken while busy");

endmodule
`default_nettype wire

FILE: design/dirty_rectangle_extractor.sv
// Top level of the dirty rectangle extractor: configuration registers and block wiring.
// Each pixel or drain item is taken in the idle state; the pop state then reads the queue
// and the out state loads the output register. A line end first runs the merge walk and
// flushes the previous line's unmatched runs, and a frame end also flushes the last line.
// The back end takes no new item until the last one is in the output register.
// Reset (synchronous, active high) clears counters, queue pointers and overflow at once.
`default_nettype none
module dirty_rectangle_extractor #(
  parameter int LINE_PIXELS = dre_pkg::LINE_PIXELS_DEF,
  parameter int MAX_LINES   = dre_pkg::MAX_LINES_DEF,
  parameter int QUEUE_DEPTH = dre_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  dre_pkg::in_item_t                 in_data,
  output logic                              out_valid,
  input  logic                              out_stall,
  output dre_pkg::out_item_t                out_data,
  input  logic                              cfg_we,
  input  logic [dre_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [dre_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import dre_pkg::*;

  logic [7:0]  frame_width;
  logic [8:0]  frame_height;
  logic [1:0]  scale;
  cfg_t        cfg;
  logic        item_valid;
  logic        item_take;
  front_item_t item;

  // Configuration registers; writes beyond the register list are ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= FRAME_WIDTH_RST;
      frame_height <= FRAME_HEIGHT_RST;
      scale        <= SCALE_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_FRAME_WIDTH:  frame_width  <= cfg_data[7:0];
        REG_FRAME_HEIGHT: frame_height <= cfg_data;
        REG_SCALE:        scale        <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  // Effective frame size: zero counts as one, and the size is clamped to the
  // line buffer and the line limit.
  always_comb begin
    if (frame_width == 8'd0) begin
      cfg.effw = 9'd1;
    end else if ({1'b0, frame_width} > 9'(LINE_PIXELS)) begin
      cfg.effw = 9'(LINE_PIXELS);
    end else begin
      cfg.effw = {1'b0, frame_width};
    end
    if (frame_height == 9'd0) begin
      cfg.effh = 9'd1;
    end else if (frame_height > 9'(MAX_LINES)) begin
      cfg.effh = 9'(MAX_LINES);
    end else begin
      cfg.effh = frame_height;
    end
    cfg.scale = scale;
  end

  // The front end buffers up to two classified items, so the input keeps taking
  // transfers while the back end walks a line end, until both entries are full.
  dre_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .item_valid (item_valid),
    .item       (item),
    .item_take  (item_take)
  );

  // The back end builds runs, merges them at each line end, queues finished
  // rectangles and pops one per item into the output register.
  dre_back #(
    .LINE_PIXELS (LINE_PIXELS),
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .item_valid (item_valid),
    .item       (item),
    .item_take  (item_take),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data)
  );

endmodule
`default_nettype wire
